// ===== rtl/atr_te_pkg.sv =====
// atr_te_pkg: types, constants and helpers shared by the atr trailing exit block
// used by atr_te_front, atr_te_fifo, atr_te_back and atr_trailing_exit_top
`default_nettype none

package atr_te_pkg;

   localparam int unsigned PRICE_W     = 32;
   localparam int unsigned GAIN_W      = 16;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned FRAC_W      = 8;
   localparam int unsigned PROD_W      = GAIN_W + PRICE_W;
   localparam int unsigned SCALED_W    = PROD_W - FRAC_W;
   localparam int unsigned BAND_W      = 42;
   localparam int unsigned WIDE_W      = 44;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REQ_TDATA_W = 264;
   localparam int unsigned RSP_TDATA_W = 72;
   localparam int unsigned RSP_BITS    = 3 + 2 * PRICE_W;

   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // 0.0005 in q16.16, used when the incoming atr is zero
   localparam logic [PRICE_W-1:0] ATR_FLOOR = 32'd33;
   localparam int unsigned WIN_PIPS  = 150;
   localparam int unsigned LOSS_PIPS = 120;

   localparam logic [TIME_W-1:0]  TIME_LIMIT_RST  = 32'd3600;
   localparam logic [GAIN_W-1:0]  STOP_MULT_RST   = 16'd512;
   localparam logic [GAIN_W-1:0]  PROFIT_MULT_RST = 16'd768;
   localparam logic [GAIN_W-1:0]  TRAIL_MULT_RST  = 16'd256;
   localparam logic [GAIN_W-1:0]  TRAIL_GAIN_RST  = 16'd128;
   localparam logic [GAIN_W-1:0]  DECAY_GAIN_RST  = 16'd26;
   localparam logic [PRICE_W-1:0] PIP_SIZE_RST    = 32'd7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIME_LIMIT  = 3'd0,
      CSR_STOP_MULT   = 3'd1,
      CSR_PROFIT_MULT = 3'd2,
      CSR_TRAIL_MULT  = 3'd3,
      CSR_TRAIL_GAIN  = 3'd4,
      CSR_DECAY_GAIN  = 3'd5,
      CSR_PIP_SIZE    = 3'd6
   } csr_idx_type;

   typedef enum logic [1:0] {
      RSN_NONE       = 2'd0,
      RSN_WEEK_END   = 2'd1,
      RSN_TIME_LIMIT = 2'd2,
      RSN_PRICE      = 2'd3
   } reason_type;

   // what the front end decided about a tick
   typedef enum logic [1:0] {
      CLS_FLAT     = 2'd0,
      CLS_WEEK_END = 2'd1,
      CLS_TIME_OUT = 2'd2,
      CLS_ACTIVE   = 2'd3
   } cls_type;

   typedef struct packed {
      logic [TIME_W-1:0]  time_limit;
      logic [GAIN_W-1:0]  stop_mult;
      logic [GAIN_W-1:0]  profit_mult;
      logic [GAIN_W-1:0]  trail_mult;
      logic [GAIN_W-1:0]  trail_gain;
      logic [GAIN_W-1:0]  decay_gain;
      logic [PRICE_W-1:0] pip_size;
   } cfg_type;

   typedef struct packed {
      cls_type            cls;
      logic               is_short;
      logic [PRICE_W-1:0] price;
      logic [PRICE_W-1:0] entry_price;
      logic [PRICE_W-1:0] atr;
      logic [PRICE_W-1:0] bar_id;
      logic [PRICE_W-1:0] bar_high;
      logic [PRICE_W-1:0] bar_low;
      logic [PRICE_W-1:0] bar_close;
   } item_type;

   typedef struct packed {
      logic [PRICE_W-1:0] profit_level;
      logic [PRICE_W-1:0] stop_level;
      reason_type         exit_reason;
      logic               exit_now;
   } result_type;

   function automatic logic [PRICE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic [PRICE_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v[WIDE_W-1:PRICE_W] != '0) begin
         r = '1;
      end else begin
         r = v[PRICE_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/atr_trailing_exit_top.sv =====
// atr_trailing_exit_top: config registers and the front end, queue and back end
// of the atr trailing exit; depends on atr_te_pkg and the atr_te_* modules
//
// channel   dir   handshake                 payload
// req_      in    req_tvalid / req_tready   req_tdata, req_tuser (kind)
// rsp_      out   rsp_tvalid / rsp_tready   rsp_tdata
// csr_      in    csr_valid / csr_ready     csr_index, csr_data
//
// in the back end a tick goes through idle and eval when it has no position, is forced
// out, exits on price or sees no new bar; the first tick adds ft1 and ft2 and a new bar
// adds tr1 to tr4, set by the two or three dependent products through the one 16x32
// multiplier. the front end takes a beat every cycle while the queue has room; a
// waiting result stalls the back end and, once the queue fills, the front end. reset
// restores the register defaults and arms the first-tick state with zero levels. csr_ready is always high.
`default_nettype none

module atr_trailing_exit_top #(
   parameter int unsigned QUEUE_DEPTH = atr_te_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [0] position_open, [1] week_end, [33:2] elapsed_time, [65:34] price,
   // [97:66] entry_price, [129:98] atr, [161:130] bar_id, [193:162] bar_high,
   // [225:194] bar_low, [257:226] bar_close, [263:258] zero
   input  wire logic [atr_te_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                                req_tuser,    // [0] kind
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] exit_now, [2:1] exit_reason, [34:3] stop_level, [66:35] profit_level,
   // [71:67] zero
   output logic [atr_te_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [atr_te_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [atr_te_pkg::CSR_DATA_W-1:0]   csr_data
);

   atr_te_pkg::cfg_type     cfg_ff, cfg_in;
   atr_te_pkg::item_type    push_item, head_item;
   atr_te_pkg::result_type  result;
   logic                    q_full, q_push, q_pop, head_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (atr_te_pkg::csr_idx_type'(csr_index))
            atr_te_pkg::CSR_TIME_LIMIT:  cfg_in.time_limit  = csr_data;
            atr_te_pkg::CSR_STOP_MULT:   cfg_in.stop_mult   = csr_data[15:0];
            atr_te_pkg::CSR_PROFIT_MULT: cfg_in.profit_mult = csr_data[15:0];
            atr_te_pkg::CSR_TRAIL_MULT:  cfg_in.trail_mult  = csr_data[15:0];
            atr_te_pkg::CSR_TRAIL_GAIN:  cfg_in.trail_gain  = csr_data[15:0];
            atr_te_pkg::CSR_DECAY_GAIN:  cfg_in.decay_gain  = csr_data[15:0];
            atr_te_pkg::CSR_PIP_SIZE:    cfg_in.pip_size    = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_limit  <= atr_te_pkg::TIME_LIMIT_RST;
         cfg_ff.stop_mult   <= atr_te_pkg::STOP_MULT_RST;
         cfg_ff.profit_mult <= atr_te_pkg::PROFIT_MULT_RST;
         cfg_ff.trail_mult  <= atr_te_pkg::TRAIL_MULT_RST;
         cfg_ff.trail_gain  <= atr_te_pkg::TRAIL_GAIN_RST;
         cfg_ff.decay_gain  <= atr_te_pkg::DECAY_GAIN_RST;
         cfg_ff.pip_size    <= atr_te_pkg::PIP_SIZE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   atr_te_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .time_limit (cfg_ff.time_limit),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   atr_te_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   atr_te_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (head_valid),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {(atr_te_pkg::RSP_TDATA_W - atr_te_pkg::RSP_BITS)'(0),
                       result.profit_level, result.stop_level,
                       result.exit_reason, result.exit_now};

endmodule

`default_nettype wire

// ===== rtl/atr_te_front.sv =====
// atr_te_front: takes request beats, unpacks them and sorts each tick
// into flat, forced exit or active; depends on atr_te_pkg
`default_nettype none

module atr_te_front (
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [atr_te_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic                                 req_tuser,
   input  wire logic [atr_te_pkg::TIME_W-1:0]        time_limit,
   input  wire logic                                 q_full,
   output logic                                      q_push,
   output atr_te_pkg::item_type                      q_item
);

   logic                             position_open;
   logic                             week_end;
   logic [atr_te_pkg::TIME_W-1:0]    elapsed_time;
   logic [atr_te_pkg::PRICE_W-1:0]   atr_raw;

   assign position_open = req_tdata[0];
   assign week_end      = req_tdata[1];
   assign elapsed_time  = req_tdata[33:2];
   assign atr_raw       = req_tdata[129:98];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_item.is_short    = req_tuser;
      q_item.price       = req_tdata[65:34];
      q_item.entry_price = req_tdata[97:66];
      q_item.atr         = (atr_raw == '0) ? atr_te_pkg::ATR_FLOOR : atr_raw;
      q_item.bar_id      = req_tdata[161:130];
      q_item.bar_high    = req_tdata[193:162];
      q_item.bar_low     = req_tdata[225:194];
      q_item.bar_close   = req_tdata[257:226];
      // week end wins over the time limit
      if (!position_open) begin
         q_item.cls = atr_te_pkg::CLS_FLAT;
      end else if (week_end) begin
         q_item.cls = atr_te_pkg::CLS_WEEK_END;
      end else if (elapsed_time > time_limit) begin
         q_item.cls = atr_te_pkg::CLS_TIME_OUT;
      end else begin
         q_item.cls = atr_te_pkg::CLS_ACTIVE;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/atr_te_fifo.sv =====
// atr_te_fifo: short queue of classified ticks between front and back end
// depends on atr_te_pkg for the item type
`default_nettype none

module atr_te_fifo #(
   parameter int unsigned DEPTH = atr_te_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire atr_te_pkg::item_type  push_item,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       head_valid,
   output atr_te_pkg::item_type       head_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   atr_te_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/atr_te_back.sv =====
// atr_te_back: position state, price exit test and level updates on one
// shared 16x32 multiplier, plus the result register; depends on atr_te_pkg
`default_nettype none

module atr_te_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire atr_te_pkg::cfg_type   cfg,
   input  wire logic                  q_valid,
   input  wire atr_te_pkg::item_type  q_item,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output atr_te_pkg::result_type     rsp_result
);

   localparam int unsigned PRICE_W  = atr_te_pkg::PRICE_W;
   localparam int unsigned GAIN_W   = atr_te_pkg::GAIN_W;
   localparam int unsigned PROD_W   = atr_te_pkg::PROD_W;
   localparam int unsigned FRAC_W   = atr_te_pkg::FRAC_W;
   localparam int unsigned SCALED_W = atr_te_pkg::SCALED_W;
   localparam int unsigned BAND_W   = atr_te_pkg::BAND_W;
   localparam int unsigned WIDE_W   = atr_te_pkg::WIDE_W;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_EVAL = 8'b0000_0010,
      ST_FT1  = 8'b0000_0100,
      ST_FT2  = 8'b0000_1000,
      ST_TR1  = 8'b0001_0000,
      ST_TR2  = 8'b0010_0000,
      ST_TR3  = 8'b0100_0000,
      ST_TR4  = 8'b1000_0000
   } state_type;

   state_type                 state_ff, state_in;
   atr_te_pkg::item_type      item_ff, item_in;
   logic                      first_ff, first_in;
   logic [PRICE_W-1:0]        stop_ff, stop_in;
   logic [PRICE_W-1:0]        target_ff, target_in;
   logic [PRICE_W-1:0]        last_bar_ff, last_bar_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic                      take_ff, take_in;
   logic [PRICE_W-1:0]        gap_mag_ff, gap_mag_in;
   logic                      dsub_ff, dsub_in;
   logic [PRICE_W-1:0]        dmag_ff, dmag_in;
   logic [PRICE_W-1:0]        s_tmp_ff, s_tmp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   atr_te_pkg::result_type    rsp_ff, rsp_in;

   logic                      emit_ok;
   logic                      emit_fire;
   logic                      is_long;
   logic [GAIN_W-1:0]         mul_a;
   logic [PRICE_W-1:0]        mul_b;
   logic                      mul_en;
   logic [SCALED_W-1:0]       scaled;
   logic signed [WIDE_W-1:0]  scaled_w, entry_w, stop_w, target_w;
   logic signed [WIDE_W-1:0]  high_w, low_w, gap_w, s_calc, t_calc;
   logic [BAND_W-1:0]         win_band, loss_band, price_b, entry_b, stop_b, target_b;
   logic                      hit, new_bar;
   logic [PRICE_W-1:0]        stop_fin, target_fin, close;

   assign is_long = !item_ff.is_short;
   assign close   = item_ff.bar_close;
   assign emit_ok = !rsp_valid_ff || rsp_tready;
   assign q_pop   = (state_ff == ST_IDLE) && q_valid;

   assign scaled   = prod_ff[PROD_W-1:FRAC_W];
   assign scaled_w = $signed(WIDE_W'(scaled));
   assign entry_w  = $signed(WIDE_W'(item_ff.entry_price));
   assign stop_w   = $signed(WIDE_W'(stop_ff));
   assign target_w = $signed(WIDE_W'(target_ff));
   assign high_w   = $signed(WIDE_W'(item_ff.bar_high));
   assign low_w    = $signed(WIDE_W'(item_ff.bar_low));

   // fixed pip bands, full width
   assign win_band  = BAND_W'(cfg.pip_size) * BAND_W'(atr_te_pkg::WIN_PIPS);
   assign loss_band = BAND_W'(cfg.pip_size) * BAND_W'(atr_te_pkg::LOSS_PIPS);
   assign price_b   = BAND_W'(item_ff.price);
   assign entry_b   = BAND_W'(item_ff.entry_price);
   assign stop_b    = BAND_W'(stop_ff);
   assign target_b  = BAND_W'(target_ff);

   always_comb begin
      if (is_long) begin
         hit = (price_b >= target_b) || (price_b <= stop_b) ||
               (price_b >= entry_b + win_band) || (price_b + loss_band <= entry_b);
      end else begin
         hit = (price_b <= target_b) || (price_b >= stop_b) ||
               (price_b + win_band <= entry_b) || (price_b >= entry_b + loss_band);
      end
   end

   assign new_bar = (item_ff.bar_id != last_bar_ff);

   // shared multiplier operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b0;
      case (state_ff)
         ST_EVAL: begin
            mul_a  = first_ff ? cfg.profit_mult : cfg.trail_mult;
            mul_b  = item_ff.atr;
            mul_en = 1'b1;
         end
         ST_FT1: begin
            mul_a  = cfg.stop_mult;
            mul_b  = item_ff.atr;
            mul_en = 1'b1;
         end
         ST_TR2: begin
            mul_a  = cfg.trail_gain;
            mul_b  = gap_mag_ff;
            mul_en = 1'b1;
         end
         ST_TR3: begin
            mul_a  = cfg.decay_gain;
            mul_b  = dmag_ff;
            mul_en = 1'b1;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
      prod_in = mul_en ? (PROD_W'(mul_a) * PROD_W'(mul_b)) : prod_ff;
   end

   // bar update arithmetic
   always_comb begin
      gap_w  = is_long ? (high_w - scaled_w - stop_w) : (low_w + scaled_w - stop_w);
      s_calc = is_long ? (stop_w + scaled_w) : (stop_w - scaled_w);
      t_calc = dsub_ff ? (target_w - scaled_w) : (target_w + scaled_w);
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      first_in     = first_ff;
      stop_in      = stop_ff;
      target_in    = target_ff;
      last_bar_in  = last_bar_ff;
      take_in      = take_ff;
      gap_mag_in   = gap_mag_ff;
      dsub_in      = dsub_ff;
      dmag_in      = dmag_ff;
      s_tmp_in     = s_tmp_ff;
      rsp_in       = rsp_ff;
      emit_fire    = 1'b0;
      stop_fin     = stop_ff;
      target_fin   = target_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               item_in  = q_item;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (item_ff.cls == atr_te_pkg::CLS_FLAT) begin
               if (emit_ok) begin
                  emit_fire          = 1'b1;
                  rsp_in.exit_now    = 1'b0;
                  rsp_in.exit_reason = atr_te_pkg::RSN_NONE;
                  state_in           = ST_IDLE;
               end
            end else if (item_ff.cls != atr_te_pkg::CLS_ACTIVE) begin
               if (emit_ok) begin
                  emit_fire          = 1'b1;
                  first_in           = 1'b1;
                  rsp_in.exit_now    = 1'b1;
                  rsp_in.exit_reason = (item_ff.cls == atr_te_pkg::CLS_WEEK_END) ?
                                       atr_te_pkg::RSN_WEEK_END :
                                       atr_te_pkg::RSN_TIME_LIMIT;
                  state_in           = ST_IDLE;
               end
            end else if (first_ff) begin
               state_in = ST_FT1;
            end else if (hit) begin
               if (emit_ok) begin
                  emit_fire          = 1'b1;
                  first_in           = 1'b1;
                  rsp_in.exit_now    = 1'b1;
                  rsp_in.exit_reason = atr_te_pkg::RSN_PRICE;
                  state_in           = ST_IDLE;
               end
            end else if (new_bar) begin
               state_in = ST_TR1;
            end else if (emit_ok) begin
               emit_fire          = 1'b1;
               rsp_in.exit_now    = 1'b0;
               rsp_in.exit_reason = atr_te_pkg::RSN_NONE;
               state_in           = ST_IDLE;
            end
         end
         ST_FT1: begin
            // product holds profit distance
            target_in = atr_te_pkg::sat32(is_long ? (entry_w + scaled_w) :
                                                    (entry_w - scaled_w));
            state_in  = ST_FT2;
         end
         ST_FT2: begin
            stop_fin = atr_te_pkg::sat32(is_long ? (entry_w - scaled_w) :
                                                   (entry_w + scaled_w));
            if (emit_ok) begin
               emit_fire          = 1'b1;
               stop_in            = stop_fin;
               first_in           = 1'b0;
               last_bar_in        = item_ff.bar_id;
               rsp_in.exit_now    = 1'b0;
               rsp_in.exit_reason = atr_te_pkg::RSN_NONE;
               state_in           = ST_IDLE;
            end
         end
         ST_TR1: begin
            // product holds the trail offset; a negative short gap fits in 32 bits
            take_in    = is_long ? (gap_w > 0) : (gap_w < 0);
            gap_mag_in = is_long ? gap_w[PRICE_W-1:0] :
                                   (~gap_w[PRICE_W-1:0] + 1'b1);
            dsub_in    = (target_ff > close);
            dmag_in    = (target_ff > close) ? (target_ff - close) : (close - target_ff);
            state_in   = ST_TR2;
         end
         ST_TR2: begin
            state_in = ST_TR3;
         end
         ST_TR3: begin
            s_tmp_in = take_ff ? atr_te_pkg::sat32(s_calc) : stop_ff;
            state_in = ST_TR4;
         end
         ST_TR4: begin
            stop_fin   = s_tmp_ff;
            target_fin = atr_te_pkg::sat32(t_calc);
            if (is_long) begin
               if (s_tmp_ff > close) begin
                  stop_fin = close;
               end else if (target_fin < close) begin
                  target_fin = close;
               end
            end else begin
               if (s_tmp_ff < close) begin
                  stop_fin = close;
               end else if (target_fin > close) begin
                  target_fin = close;
               end
            end
            if (emit_ok) begin
               emit_fire          = 1'b1;
               stop_in            = stop_fin;
               target_in          = target_fin;
               last_bar_in        = item_ff.bar_id;
               rsp_in.exit_now    = 1'b0;
               rsp_in.exit_reason = atr_te_pkg::RSN_NONE;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.stop_level   = emit_fire ? stop_in : rsp_ff.stop_level;
      rsp_in.profit_level = emit_fire ? target_in : rsp_ff.profit_level;
      rsp_valid_in        = emit_fire ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b1;
         stop_ff      <= '0;
         target_ff    <= '0;
         last_bar_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         stop_ff      <= stop_in;
         target_ff    <= target_in;
         last_bar_ff  <= last_bar_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      prod_ff    <= prod_in;
      take_ff    <= take_in;
      gap_mag_ff <= gap_mag_in;
      dsub_ff    <= dsub_in;
      dmag_ff    <= dmag_in;
      s_tmp_ff   <= s_tmp_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

`default_nettype wire
